// File: rtl/core/wsh_pkg.sv
// ----------------------------------------------------------------------------
// wsh_pkg: shared types and constants of the windowed sample histogram
// Register indexes, reset values, default sizes and the item that passes
// from the front (sample classification) to the back (bin update and dump).
// ----------------------------------------------------------------------------
package wsh_pkg;

  // Default sizes of the bin store
  localparam int MAX_BINS_DEF    = 64;
  localparam int COUNT_WIDTH_DEF = 16;

  // Widest bin index and bin number over the supported range of MAX_BINS
  localparam int BIN_W = 8;
  localparam int NUM_W = 9;

  // Entries between front and back
  localparam int QUEUE_DEPTH = 4;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_BIN_COUNT     = 2'd1;

  // Register reset values
  localparam logic [15:0] WINDOW_RESET = 16'd2048;
  localparam logic [6:0]  BINS_RESET   = 7'd50;

  // One classified sample
  typedef struct packed {
    logic             eow;    // this sample closes the window
    logic [NUM_W-1:0] nbins;  // active bin number when classified
    logic [BIN_W-1:0] bin;    // target bin
  } wsh_item_t;

endpackage

// File: rtl/core/wsh_front.sv
// ----------------------------------------------------------------------------
// wsh_front: configuration registers and sample classification
// Maps each accepted sample to its amplitude bin, counts samples in the
// window and marks the sample that closes it.
// ----------------------------------------------------------------------------
module wsh_front #(
  parameter int MAX_BINS = wsh_pkg::MAX_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wsh_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [15:0]                        cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic signed [15:0]                 sample,
  input  logic                               q_full,
  output logic                               q_push,
  output wsh_pkg::wsh_item_t                 q_item
);
  import wsh_pkg::*;

  localparam int MW = $clog2(MAX_BINS + 1);
  localparam int EW = (MW > 7) ? MW : 7;
  localparam int PW = 16 + MW;

  logic [15:0]   window_length;
  logic [6:0]    bin_count;
  logic [15:0]   samples_in_window;

  logic [MW-1:0] nbins;
  logic [15:0]   offset;
  logic [PW-1:0] prod;
  logic [MW-1:0] bin_raw;
  logic [MW-1:0] bin_sel;
  logic [15:0]   win_act;
  logic [15:0]   cnt_inc;
  logic          eow;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign q_push    = push && !q_full;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WINDOW_RESET;
      bin_count     <= BINS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WINDOW_LENGTH) begin
        window_length <= cfg_data;
      end else if (cfg_index == REG_BIN_COUNT) begin
        bin_count <= cfg_data[6:0];
      end
    end
  end

  // Clamp bin number to 1..MAX_BINS
  always_comb begin
    if (bin_count == 7'd0) begin
      nbins = MW'(1);
    end else if (EW'(bin_count) > EW'(MAX_BINS)) begin
      nbins = MW'(MAX_BINS);
    end else begin
      nbins = MW'(bin_count);
    end
  end

  // Classify: bin = (offset binary sample * nbins) >> 16
  assign offset  = {~sample[15], sample[14:0]};
  assign prod    = PW'(offset) * PW'(nbins);
  assign bin_raw = prod[PW-1:16];
  assign bin_sel = (bin_raw >= nbins) ? (nbins - MW'(1)) : bin_raw;

  // Detect window end
  assign win_act = (window_length == 16'd0) ? 16'd1 : window_length;
  assign cnt_inc = samples_in_window + 16'd1;
  assign eow     = (cnt_inc >= win_act);

  assign q_item.eow   = eow;
  assign q_item.nbins = NUM_W'(nbins);
  assign q_item.bin   = BIN_W'(bin_sel);

  // Advance sample count, restart at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      samples_in_window <= 16'd0;
    end else if (q_push) begin
      samples_in_window <= eow ? 16'd0 : cnt_inc;
    end
  end

endmodule

// File: rtl/core/wsh_queue.sv
// ----------------------------------------------------------------------------
// wsh_queue: short queue of classified samples
// Decouples the front from the back so that each side stalls on its own.
// ----------------------------------------------------------------------------
module wsh_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  wsh_pkg::wsh_item_t wr_item,
  output logic               q_full,
  input  logic               rd_en,
  output logic               q_valid,
  output wsh_pkg::wsh_item_t rd_item
);
  import wsh_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  wsh_item_t     slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;

  assign q_full  = (fill == CW'(QUEUE_DEPTH));
  assign q_valid = (fill != CW'(0));
  assign rd_item = slots[rd_ptr];

  // Store entries
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_en && !rd_en) begin
        fill <= fill + CW'(1);
      end else if (rd_en && !wr_en) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

// File: rtl/core/wsh_back.sv
// ----------------------------------------------------------------------------
// wsh_back: bin store, count update and window dump
// Increments the target bin of each sample with saturation and, at window
// end, reads out the active bins in order and invalidates the whole store.
// ----------------------------------------------------------------------------
module wsh_back #(
  parameter int MAX_BINS    = wsh_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = wsh_pkg::COUNT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  wsh_pkg::wsh_item_t q_item,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         bin_index,
  output logic [15:0]        bin_total,
  output logic               last_bin
);
  import wsh_pkg::*;

  localparam int BW = $clog2(MAX_BINS);
  localparam int MW = $clog2(MAX_BINS + 1);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_DRD,
    S_DWR
  } state_t;

  state_t                 state;
  wsh_item_t              cur;
  logic [BW-1:0]          k;
  logic                   out_valid;

  logic [COUNT_WIDTH-1:0] mem [MAX_BINS];
  logic [MAX_BINS-1:0]    valid;
  logic [COUNT_WIDTH-1:0] rd_data;
  logic                   rd_hit;

  logic                   slot_free;
  logic                   rd_en;
  logic [BW-1:0]          rd_addr;
  logic                   wr_en;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] wr_data;
  logic                   dump_last;

  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign q_pop     = (state == S_IDLE) && q_valid;

  // Select read port address: sample bin or dump position
  assign rd_addr = (state == S_IDLE) ? q_item.bin[BW-1:0] : k;
  assign rd_en   = q_pop || ((state == S_DRD) && slot_free);

  // Saturating increment of the stored count
  assign cnt_cur = rd_hit ? rd_data : '0;
  assign wr_data = (cnt_cur == CNT_MAX) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
  assign wr_en   = (state == S_UPD);

  assign dump_last = ((MW'(k) + MW'(1)) == cur.nbins[MW-1:0]);

  // Bin store: one write, one registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[cur.bin[BW-1:0]] <= wr_data;
    end
  end

  // Track written entries; invalidate all at window end
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_hit <= valid[rd_addr];
      end
      if (wr_en) begin
        valid[cur.bin[BW-1:0]] <= 1'b1;
      end else if ((state == S_DWR) && dump_last) begin
        valid <= '0;
      end
    end
  end

  // Sequence updates and dumps, hold the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          k     <= '0;
          state <= cur.eow ? S_DRD : S_IDLE;
        end
        S_DRD: begin
          if (slot_free) begin
            state <= S_DWR;
          end
        end
        S_DWR: begin
          out_valid <= 1'b1;
          bin_index <= 6'(k);
          bin_total <= 16'(cnt_cur);
          last_bin  <= dump_last;
          if (dump_last) begin
            state <= S_IDLE;
          end else begin
            k     <= k + BW'(1);
            state <= S_DRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/core/windowed_sample_histogram_unit.sv
// ----------------------------------------------------------------------------
// windowed_sample_histogram_unit: windowed amplitude histogram
// Sorts Q1.15 samples into equal-width amplitude bins and, after each
// window, reports one count per active bin in bin order.
//
//   channel   direction  handshake            payload
//   config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   samples   in         push/full            sample
//   results   out        empty/pop            bin_index, bin_total, last_bin
//
// A sample is classified in its accept cycle and queued (four entries); the
// back then updates its bin by a read-modify-write through the registered
// read port of the bin store and takes the next sample only once it is done.
// A window end adds a dump of each active bin (store read, then result
// register), longer when pop stalls; full rises once the queue fills.
// Reset clears the entry valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module windowed_sample_histogram_unit #(
  parameter int MAX_BINS    = wsh_pkg::MAX_BINS_DEF,
  parameter int COUNT_WIDTH = wsh_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wsh_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [15:0]                     cfg_data,
  input  logic                            push,
  output logic                            full,
  input  logic signed [15:0]              sample,
  output logic                            empty,
  input  logic                            pop,
  output logic [5:0]                      bin_index,
  output logic [15:0]                     bin_total,
  output logic                            last_bin
);
  import wsh_pkg::*;

  logic      q_full;
  logic      q_push;
  logic      q_valid;
  logic      q_pop;
  wsh_item_t fr_item;
  wsh_item_t bk_item;

  // Classify samples
  wsh_front #(
    .MAX_BINS(MAX_BINS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (fr_item)
  );

  // Buffer classified samples
  wsh_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (fr_item),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .q_valid (q_valid),
    .rd_item (bk_item)
  );

  // Update bins and dump windows
  wsh_back #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (bk_item),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .bin_index (bin_index),
    .bin_total (bin_total),
    .last_bin  (last_bin)
  );

endmodule

// File: rtl/core/wsh_checker.sv
// ----------------------------------------------------------------------------
// wsh_checker: port-level checks of the histogram unit
// Watches reset state, result stalls and result spacing on the top level.
// ----------------------------------------------------------------------------
module wsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [5:0]  bin_index,
  input logic [15:0] bin_total,
  input logic        last_bin
);

  // Come out of reset with no results and room for samples
  a_reset_clean: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("results pending or input full after reset");

  // Hold a stalled result beat
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(bin_index) && $stable(bin_total)
                          && $stable(last_bin)))
    else $error("stalled result beat changed");

  // Keep the result register empty in the cycle after a pop
  a_result_gap: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("result register refilled in the pop cycle");

endmodule

bind windowed_sample_histogram_unit wsh_checker u_wsh_checker (
  .clk       (clk),
  .rst       (rst),
  .full      (full),
  .empty     (empty),
  .pop       (pop),
  .bin_index (bin_index),
  .bin_total (bin_total),
  .last_bin  (last_bin)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for windowed_sample_histogram_unit
// A directed table covers the field extremes, the bin boundaries, the clamped
// bin and window settings, and the registers rewritten in the middle of a
// window. Random windows follow under three idle mixes. Every result beat is
// checked against a local tally or, for typed rows, against the row's beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import wsh_pkg::*;

  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int PHASE_ITEMS  = 72;
  localparam int unsigned COUNT_MAX = (1 << COUNT_WIDTH_DEF) - 1;

  // Index codes that the block leaves unused
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [5:0]  idx;
    logic [15:0] total;
    logic        last;
  } bin_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_TYPED} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_INDEX_W-1:0] index;
    logic [15:0]           data;
    logic [15:0]           smp;
    bin_result_t           want;
  } row_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [15:0]            cfg_data  = '0;
  logic                   push      = 1'b0;
  logic                   full;
  logic signed [15:0]     sample    = '0;
  logic                   empty;
  logic                   pop       = 1'b0;
  logic [5:0]             bin_index;
  logic [15:0]            bin_total;
  logic                   last_bin;

  // Local copy of the block state
  int unsigned   hist [MAX_BINS_DEF];
  logic [15:0]   win_len_reg;
  logic [6:0]    bins_reg;
  logic [15:0]   win_fill;

  bin_result_t   pending_bins [$];
  row_t          plan [$];
  int            mismatches  = 0;
  int            send_idle   = 0;
  int            recv_idle   = 0;
  int            items_sent  = 0;
  int            cycle_count = 0;
  bit            hold_done   = 0;

  windowed_sample_histogram_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .sample    (sample),
    .empty     (empty),
    .pop       (pop),
    .bin_index (bin_index),
    .bin_total (bin_total),
    .last_bin  (last_bin)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Bin number in force: zero acts as one, above the store size clamps
  function automatic int unsigned live_bins();
    int unsigned m;
    m = 32'(bins_reg);
    if (m == 0) m = 1;
    if (m > MAX_BINS_DEF) m = MAX_BINS_DEF;
    return m;
  endfunction

  // Count one accepted sample; on window end queue one beat per active bin if keep is set
  task automatic tally_sample(input logic [15:0] s, input bit keep);
    int unsigned m;
    int unsigned u;
    int unsigned b;
    int unsigned wl;
    bin_result_t r;
    m = live_bins();
    u = {16'd0, ~s[15], s[14:0]};
    b = (u * m) >> 16;
    if (b >= m) b = m - 1;
    if (hist[b] < COUNT_MAX) hist[b]++;
    win_fill = win_fill + 16'd1;
    wl = (win_len_reg == 16'd0) ? 32'd1 : 32'(win_len_reg);
    if (win_fill >= wl) begin
      for (int k = 0; k < m; k++) begin
        r.idx   = k[5:0];
        r.total = hist[k][15:0];
        r.last  = (k == m - 1);
        if (keep) pending_bins.push_back(r);
      end
      for (int k = 0; k < MAX_BINS_DEF; k++) hist[k] = 0;
      win_fill = '0;
    end
  endtask

  // Wait for the result queue to drain, then let the back end settle
  task automatic wait_idle();
    push <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] d);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) win_len_reg = d;
    else if (idx == REG_BIN_COUNT) bins_reg = d[6:0];
  endtask

  // Send one sample beat; push stays high so the next beat can follow
  task automatic push_sample(input logic [15:0] s, input bit keep);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push   <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (full) @(posedge clk);
    tally_sample(s, keep);
    items_sent++;
  endtask

  // Mix of full-range values, extremes and codes next to bin boundaries
  function automatic logic [15:0] pick_sample();
    int unsigned m;
    int unsigned k;
    int unsigned u;
    logic [15:0] uv;
    m = live_bins();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7FFF;
          2: return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default: begin
        if (m < 2) return 16'($urandom);
        k  = $urandom_range(1, m - 1);
        u  = (k * 65536 + m - 1) / m + $urandom_range(2) - 1;
        uv = u[15:0];
        return {~uv[15], uv[14:0]};
      end
    endcase
  endfunction

  task automatic plan_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] d);
    row_t r;
    r = '0;
    r.kind  = ROW_CFG;
    r.index = idx;
    r.data  = d;
    plan.push_back(r);
  endtask

  task automatic plan_sample(input logic [15:0] s);
    row_t r;
    r = '0;
    r.kind = ROW_SAMPLE;
    r.smp  = s;
    plan.push_back(r);
  endtask

  // Single-bin, single-sample window: the one beat is bin 0, count 1, last
  task automatic plan_typed(input logic [15:0] s);
    row_t r;
    r = '0;
    r.kind = ROW_TYPED;
    r.smp  = s;
    r.want = '{idx: 6'd0, total: 16'd1, last: 1'b1};
    plan.push_back(r);
  endtask

  // One random setting, then a run of samples, partial windows included
  task automatic random_segment();
    int unsigned win;
    int unsigned nb;
    int unsigned n;
    logic [15:0] d;
    case ($urandom_range(11))
      0: win = 0;
      1: win = 1;
      2: win = 16'hFFFF;
      default: win = $urandom_range(2, 12);
    endcase
    case ($urandom_range(7))
      0: nb = 0;
      1: nb = 1;
      2: nb = MAX_BINS_DEF;
      3: nb = $urandom_range(MAX_BINS_DEF + 1, 127);
      default: nb = $urandom_range(2, MAX_BINS_DEF - 1);
    endcase
    d = 16'($urandom);
    d[6:0] = nb[6:0];
    if ($urandom_range(1)) begin
      write_reg(REG_BIN_COUNT, d);
      write_reg(REG_WINDOW_LENGTH, win[15:0]);
    end else begin
      write_reg(REG_WINDOW_LENGTH, win[15:0]);
      write_reg(REG_BIN_COUNT, d);
    end
    if ($urandom_range(7) == 0)
      write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
    if (win == 0) win = 1;
    if (win > 10) win = 10;
    n = $urandom_range(1, 3 * win);
    for (int i = 0; i < n; i++) begin
      // Hold off the sender until every queued beat is out
      if (i == n / 2 && (!hold_done || $urandom_range(9) == 0)) begin
        push <= 1'b0;
        @(posedge clk);
        while (pending_bins.size() != 0) @(posedge clk);
        hold_done = 1;
      end
      push_sample(pick_sample(), 1'b1);
    end
  endtask

  // Result side: random pop, check each accepted beat
  always @(posedge clk) begin
    bin_result_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (pending_bins.size() == 0) begin
          report_mismatch($sformatf("unexpected beat bin %0d total %0d", bin_index, bin_total));
        end else begin
          want = pending_bins.pop_front();
          if (bin_index !== want.idx)
            report_mismatch($sformatf("bin_index %0d, want %0d", bin_index, want.idx));
          if (bin_total !== want.total)
            report_mismatch($sformatf("bin_total %0d, want %0d (bin %0d)",
                                      bin_total, want.total, want.idx));
          if (last_bin !== want.last)
            report_mismatch($sformatf("last_bin %0b, want %0b (bin %0d)",
                                      last_bin, want.last, want.idx));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int phase_start;
    win_len_reg = WINDOW_RESET;
    bins_reg    = BINS_RESET;
    win_fill    = '0;
    for (int k = 0; k < MAX_BINS_DEF; k++) hist[k] = 0;

    // Single bin, single sample: extremes, then zero settings acting as one
    plan_cfg(REG_WINDOW_LENGTH, 16'd1);
    plan_cfg(REG_BIN_COUNT, 16'd1);
    plan_typed(16'h8000);
    plan_typed(16'h7FFF);
    plan_typed(16'h0000);
    plan_cfg(REG_BIN_COUNT, 16'd0);
    plan_cfg(REG_WINDOW_LENGTH, 16'd0);
    plan_typed(16'hFFFF);
    plan_typed(16'h0001);
    // Full store: outer bins and both sides of the first boundary
    plan_cfg(REG_BIN_COUNT, 16'd64);
    plan_cfg(REG_WINDOW_LENGTH, 16'd4);
    plan_sample(16'h8000);
    plan_sample(16'h7FFF);
    plan_sample(-16'sd31744);
    plan_sample(-16'sd31745);
    // Bin count above the store size, junk in the upper data bits
    plan_cfg(REG_BIN_COUNT, 16'hFF64);
    plan_cfg(REG_WINDOW_LENGTH, 16'd3);
    plan_sample(16'h0000);
    plan_sample(16'hFFFF);
    plan_sample(16'h0001);
    // Uneven boundary at the reset bin count
    plan_cfg(REG_BIN_COUNT, {9'd0, BINS_RESET});
    plan_cfg(REG_WINDOW_LENGTH, 16'd2);
    plan_sample(-16'sd31457);
    plan_sample(-16'sd31458);
    // Widest window, then shortened below the fill: ends on the next sample
    plan_cfg(REG_WINDOW_LENGTH, 16'hFFFF);
    plan_cfg(REG_BIN_COUNT, 16'd3);
    plan_sample(-16'sd10922);
    plan_sample(-16'sd10923);
    plan_sample(16'h7FFF);
    plan_sample(16'h0000);
    plan_sample(16'h8000);
    plan_cfg(REG_WINDOW_LENGTH, 16'd2);
    plan_sample(16'sd12345);
    // Bin count lowered mid-window: high bins dropped and cleared
    plan_cfg(REG_WINDOW_LENGTH, 16'd6);
    plan_cfg(REG_BIN_COUNT, 16'd8);
    plan_sample(16'h7FFF);
    plan_sample(16'h7FFF);
    plan_sample(16'h7FFF);
    plan_cfg(REG_BIN_COUNT, 16'd4);
    plan_sample(16'h8000);
    plan_sample(16'h0000);
    plan_sample(16'sd16384);
    plan_cfg(REG_SPARE_A, 16'h5A5A);
    plan_cfg(REG_SPARE_B, 16'hA5A5);

    send_idle = 8;
    recv_idle = 52;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_CFG: begin
          write_reg(plan[i].index, plan[i].data);
        end
        ROW_SAMPLE: begin
          push_sample(plan[i].smp, 1'b1);
        end
        default: begin
          push_sample(plan[i].smp, 1'b0);
          pending_bins.push_back(plan[i].want);
        end
      endcase
    end

    // Random windows under three idle mixes
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 8;
          recv_idle = 52;
        end
        1: begin
          send_idle = 52;
          recv_idle = 8;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) random_segment();
    end

    push <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/wsh_pkg.sv
rtl/core/wsh_front.sv
rtl/core/wsh_queue.sv
rtl/core/wsh_back.sv
rtl/core/windowed_sample_histogram_unit.sv
rtl/core/wsh_checker.sv
tb/tb.sv
